@@ rtl/pqe_pkg.sv @@
`timescale 1ns / 1ps

package pqe_pkg;

   localparam int TERMS     = 6;
   localparam int DATA_W    = 32;
   localparam int FRAC_W    = 16;
   localparam int ACC_W     = 35;
   localparam int ADDR_W    = 16;
   localparam int BANK_W    = 3;
   localparam int IDX_W     = 13;
   localparam int QUOT_W    = 11;
   localparam int PC_W      = 11;
   localparam int CSR_IDX_W = 2;
   localparam int TDATA_W   = 80;

   // idx / 6 == (idx * 10923) >> 16 for idx below 2^15
   localparam logic [13:0] DIV6_RECIP = 14'd10923;
   localparam int          DIV6_SHIFT = 16;

   localparam logic [FRAC_W:0]   FRAC_ONE          = 17'h1_0000;
   localparam logic [DATA_W-1:0] RESET_SAMPLE_RATE = 32'h0001_0000;
   localparam logic [PC_W-1:0]   RESET_POINT_COUNT = 11'd2;
   localparam logic [DATA_W-1:0] SAT_POS           = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] SAT_NEG           = 32'h8000_0000;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_EVAL  = 1'b1
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_TIME  = 2'd0,
      CSR_SAMPLE_RATE = 2'd1,
      CSR_POINT_COUNT = 2'd2
   } csr_index_type;

   typedef logic signed [DATA_W-1:0] coef_type;

   // element TERMS-2 is the next coefficient consumed, element 0 is c0
   typedef coef_type [TERMS-2:0] coef_vec_type;

   typedef struct packed {
      logic              valid;
      logic              is_eval;
      logic              wr_en;
      logic [BANK_W-1:0] bank;
      logic [ADDR_W-1:0] addr;
      coef_type          wdata;
      logic [FRAC_W:0]   frac;
   } front_out_type;

endpackage

@@ rtl/piecewise_quintic_evaluator.sv @@
`timescale 1ns / 1ps

// Piecewise quintic evaluator. A write transfer (tuser 0) stores one signed
// Q16.16 coefficient at address 6*interval+power; an evaluate transfer
// (tuser 1) maps its time to an interval and a Q1.16 fraction using
// start_time and sample_rate, evaluates the quintic by Horner's rule and
// returns one saturated Q16.16 value, with tuser set when it clipped. Writes
// return nothing. The block takes one transfer per cycle while the output
// side is not stalled; a result passes three front stages (offset, 32x32
// scaling multiply, clamp), the six coefficient banks, one register per
// Horner multiply-add, and the output register. A coefficient must be written
// before an evaluation reads it.

module piecewise_quintic_evaluator
   import pqe_pkg::*;
#(
   parameter int MAX_POINTS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [TDATA_W-1:0]   req_tdata,   // coef_index[12:0], coef_value[44:13],
                                              // time_req[76:45], zero pad
   input  logic                 req_tuser,   // opcode
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_W-1:0]    rsp_tdata,   // value
   output logic                 rsp_tuser,   // saturated
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   localparam int KW = $clog2(MAX_POINTS);

   logic [DATA_W-1:0] start_time_ff, sample_rate_ff;
   logic [PC_W-1:0]   point_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_time_ff  <= '0;
         sample_rate_ff <= RESET_SAMPLE_RATE;
         point_count_ff <= RESET_POINT_COUNT;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_START_TIME:  start_time_ff  <= csr_wdata;
            CSR_SAMPLE_RATE: sample_rate_ff <= csr_wdata;
            CSR_POINT_COUNT: point_count_ff <= csr_wdata[PC_W-1:0];
            default: ;
         endcase
      end
   end

   front_out_type fo;
   logic          stage_rdy [0:TERMS];

   pqe_front #(
      .MAX_POINTS(MAX_POINTS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .start_time  (start_time_ff),
      .sample_rate (sample_rate_ff),
      .point_count (point_count_ff),
      .ready_in    (stage_rdy[0]),
      .front_out   (fo)
   );

   // coefficient banks, one per power
   logic            v4_ff;
   logic [FRAC_W:0] f4_ff;
   coef_type        rdata [0:TERMS-1];

   assign stage_rdy[0] = !v4_ff || stage_rdy[1];

   for (genvar b = 0; b < TERMS; b++) begin : g_bank
      pqe_ram #(
         .WIDTH(DATA_W),
         .DEPTH(MAX_POINTS)
      ) u_ram (
         .clock (clock),
         .we    (stage_rdy[0] && fo.valid && fo.wr_en && (fo.bank == BANK_W'(b))),
         .re    (stage_rdy[0]),
         .addr  (KW'(fo.addr)),
         .wdata (fo.wdata),
         .rdata (rdata[b])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (stage_rdy[0]) begin
         v4_ff <= fo.valid && fo.is_eval;
      end
      if (stage_rdy[0]) begin
         f4_ff <= fo.frac;
      end
   end

   // Horner chain
   logic                    h_valid [0:TERMS-1];
   logic signed [ACC_W-1:0] h_acc   [0:TERMS-1];
   logic [FRAC_W:0]         h_frac  [0:TERMS-1];
   coef_vec_type            h_coefs [0:TERMS-1];

   assign h_valid[0] = v4_ff;
   assign h_acc[0]   = ACC_W'(rdata[TERMS-1]);
   assign h_frac[0]  = f4_ff;
   for (genvar j = 0; j < TERMS-1; j++) begin : g_coef
      assign h_coefs[0][j] = rdata[j];
   end

   for (genvar i = 1; i < TERMS; i++) begin : g_step
      pqe_horner_step u_step (
         .clock     (clock),
         .reset     (reset),
         .ready_in  (stage_rdy[i+1]),
         .ready_out (stage_rdy[i]),
         .valid_in  (h_valid[i-1]),
         .acc_in    (h_acc[i-1]),
         .frac_in   (h_frac[i-1]),
         .coefs_in  (h_coefs[i-1]),
         .valid_out (h_valid[i]),
         .acc_out   (h_acc[i]),
         .frac_out  (h_frac[i]),
         .coefs_out (h_coefs[i])
      );
   end

   // saturation and output register
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_sat_ff, rsp_sat_in;
   logic signed [ACC_W-1:0] acc_fin;

   assign acc_fin      = h_acc[TERMS-1];
   assign stage_rdy[TERMS] = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (acc_fin > ACC_W'($signed(SAT_POS))) begin
         rsp_data_in = SAT_POS;
         rsp_sat_in  = 1'b1;
      end else if (acc_fin < ACC_W'($signed(SAT_NEG))) begin
         rsp_data_in = SAT_NEG;
         rsp_sat_in  = 1'b1;
      end else begin
         rsp_data_in = acc_fin[DATA_W-1:0];
         rsp_sat_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_rdy[TERMS]) begin
         rsp_valid_ff <= h_valid[TERMS-1];
      end
      if (stage_rdy[TERMS]) begin
         rsp_data_ff <= rsp_data_in;
         rsp_sat_ff  <= rsp_sat_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

endmodule

@@ rtl/pqe_ram.sv @@
`timescale 1ns / 1ps

module pqe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/pqe_front.sv @@
`timescale 1ns / 1ps

module pqe_front
   import pqe_pkg::*;
#(
   parameter int MAX_POINTS = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [TDATA_W-1:0]  req_tdata,
   input  logic                req_tuser,
   input  logic [DATA_W-1:0]   start_time,
   input  logic [DATA_W-1:0]   sample_rate,
   input  logic [PC_W-1:0]     point_count,
   input  logic                ready_in,
   output front_out_type       front_out
);

   localparam int STORE_DEPTH = TERMS * MAX_POINTS;

   logic [IDX_W-1:0]  coef_index;
   logic [DATA_W-1:0] coef_value;
   logic [DATA_W-1:0] time_req;

   assign coef_index = req_tdata[IDX_W-1:0];
   assign coef_value = req_tdata[IDX_W+DATA_W-1:IDX_W];
   assign time_req   = req_tdata[IDX_W+2*DATA_W-1:IDX_W+DATA_W];

   logic ld1, ld2, ld3;

   // stage 1: offset and write-address quotient
   logic                     v1_ff, eval1_ff;
   logic signed [DATA_W:0]   d1_ff, d1_in;
   logic [IDX_W-1:0]         idx1_ff;
   coef_type                 val1_ff;
   logic [QUOT_W-1:0]        q1_ff, q1_in;
   logic [IDX_W+13:0]        q_prod;

   // stage 2: scaling product, bank select
   logic                     v2_ff, eval2_ff, pos2_ff, wok2_ff;
   logic [2*DATA_W-1:0]      p2_ff;
   logic [BANK_W-1:0]        bank2_ff;
   logic [IDX_W-1:0]         q_times6;
   logic [QUOT_W-1:0]        q2_ff;
   coef_type                 val2_ff;

   // stage 3: clamp
   front_out_type            s3_ff, s3_in;
   logic [DATA_W-1:0]        npts, last;

   assign ld3        = !s3_ff.valid || ready_in;
   assign ld2        = !v2_ff || ld3;
   assign ld1        = !v1_ff || ld2;
   assign req_tready = ld1;

   assign d1_in  = $signed({time_req[DATA_W-1], time_req})
                 - $signed({start_time[DATA_W-1], start_time});
   assign q_prod = coef_index * DIV6_RECIP;
   assign q1_in  = q_prod[DIV6_SHIFT+QUOT_W-1:DIV6_SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (ld1) begin
         v1_ff <= req_tvalid;
      end
      if (ld1) begin
         eval1_ff <= (opcode_type'(req_tuser) == OP_EVAL);
         d1_ff    <= d1_in;
         idx1_ff  <= coef_index;
         val1_ff  <= coef_value;
         q1_ff    <= q1_in;
      end
   end

   assign q_times6 = {q1_ff, 2'b00} + {1'b0, q1_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (ld2) begin
         v2_ff <= v1_ff;
      end
      if (ld2) begin
         eval2_ff <= eval1_ff;
         pos2_ff  <= (d1_ff > 0) && (sample_rate != '0);
         p2_ff    <= d1_ff[DATA_W-1:0] * sample_rate;
         bank2_ff <= BANK_W'(idx1_ff - q_times6);
         wok2_ff  <= (32'(idx1_ff) < 32'(STORE_DEPTH));
         q2_ff    <= q1_ff;
         val2_ff  <= val1_ff;
      end
   end

   always_comb begin
      if (point_count < PC_W'(2)) begin
         npts = 32'd2;
      end else if (32'(point_count) > 32'(MAX_POINTS)) begin
         npts = 32'(MAX_POINTS);
      end else begin
         npts = 32'(point_count);
      end
      last = npts - 32'd2;

      s3_in.valid   = v2_ff;
      s3_in.is_eval = eval2_ff;
      s3_in.wr_en   = !eval2_ff && wok2_ff;
      s3_in.bank    = bank2_ff;
      s3_in.wdata   = val2_ff;
      if (!eval2_ff) begin
         s3_in.addr = ADDR_W'(q2_ff);
         s3_in.frac = '0;
      end else if (!pos2_ff) begin
         s3_in.addr = '0;
         s3_in.frac = '0;
      end else if (p2_ff[2*DATA_W-1:DATA_W] > last) begin
         s3_in.addr = last[ADDR_W-1:0];
         s3_in.frac = FRAC_ONE;
      end else begin
         s3_in.addr = p2_ff[DATA_W+ADDR_W-1:DATA_W];
         s3_in.frac = {1'b0, p2_ff[DATA_W-1:FRAC_W]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid <= 1'b0;
      end else if (ld3) begin
         s3_ff.valid <= s3_in.valid;
      end
      if (ld3) begin
         s3_ff.is_eval <= s3_in.is_eval;
         s3_ff.wr_en   <= s3_in.wr_en;
         s3_ff.bank    <= s3_in.bank;
         s3_ff.addr    <= s3_in.addr;
         s3_ff.wdata   <= s3_in.wdata;
         s3_ff.frac    <= s3_in.frac;
      end
   end

   assign front_out = s3_ff;

endmodule

@@ rtl/pqe_horner_step.sv @@
`timescale 1ns / 1ps

module pqe_horner_step
   import pqe_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    ready_in,
   output logic                    ready_out,
   input  logic                    valid_in,
   input  logic signed [ACC_W-1:0] acc_in,
   input  logic [FRAC_W:0]         frac_in,
   input  coef_vec_type            coefs_in,
   output logic                    valid_out,
   output logic signed [ACC_W-1:0] acc_out,
   output logic [FRAC_W:0]         frac_out,
   output coef_vec_type            coefs_out
);

   logic                          ld;
   logic                          valid_ff;
   logic signed [ACC_W-1:0]       acc_ff, acc_in_next;
   logic [FRAC_W:0]               frac_ff;
   coef_vec_type                  coefs_ff, coefs_in_next;
   logic signed [ACC_W+FRAC_W+1:0] prod;

   assign ld        = !valid_ff || ready_in;
   assign ready_out = ld;

   // floor(acc * f / 2^16) + c
   assign prod          = acc_in * $signed({1'b0, frac_in});
   assign acc_in_next   = ACC_W'(prod >>> FRAC_W) + ACC_W'(coefs_in[TERMS-2]);
   assign coefs_in_next = {coefs_in[TERMS-3:0], coef_type'(0)};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ld) begin
         valid_ff <= valid_in;
      end
      if (ld) begin
         acc_ff   <= acc_in_next;
         frac_ff  <= frac_in;
         coefs_ff <= coefs_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign acc_out   = acc_ff;
   assign frac_out  = frac_ff;
   assign coefs_out = coefs_ff;

endmodule

@@ rtl/pqe_checker.sv @@
`timescale 1ns / 1ps

module pqe_checker
   import pqe_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic              rsp_tuser
);

   // no result right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a free output slot lets the whole pipeline move
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input stalled while output can drain");

   // clipped results sit on a range limit
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == SAT_POS || rsp_tdata == SAT_NEG))
      else $error("saturation flag with unclipped value");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind piecewise_quintic_evaluator pqe_checker u_pqe_checker (.*);
